/* design/assert_macros.svh */
// Assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* design/chm_pkg.sv */
`timescale 1ns / 1ps
package chm_pkg;
   localparam int NumBuckets = 256;
   localparam int NumEntries = 256;
   localparam int MaxKeyBytes = 8;
   localparam int BktW = $clog2(NumBuckets);
   localparam int EntW = $clog2(NumEntries);
   localparam int LnkW = EntW + 1;
   localparam int CntW = $clog2(NumEntries + 1);
   localparam int StepW = $clog2(NumEntries + 1);
   localparam logic [63:0] FnvOffset = 64'hCBF29CE484222325;
   localparam logic [63:0] FnvPrime = 64'h00000100000001B3;
   localparam logic [LnkW-1:0] NilLink = LnkW'(NumEntries);

   localparam logic [1:0] ReqSet = 2'd0;
   localparam logic [1:0] ReqGet = 2'd1;
   localparam logic [1:0] ReqPop = 2'd2;
   localparam logic [1:0] ReqDel = 2'd3;

   localparam logic [1:0] StOk = 2'd0;
   localparam logic [1:0] StMiss = 2'd1;
   localparam logic [1:0] StFull = 2'd2;

   // controller to datapath commands
   typedef struct packed {
      logic load;       // capture request
      logic hash_step;  // one 16-bit partial product step
      logic head_rd;    // read bucket head
      logic advance;    // move cursor down the chain
      logic found_set;  // record match at cursor
      logic wr_value;   // update value of found entry
      logic insert;     // write new entry and link it
      logic unlink;     // unlink found entry
      logic finish;     // present result
      logic [1:0] status;
      logic clr_sweep;  // clear one bucket head
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic hash_done;
      logic at_nil;
      logic match;
      logic is_found;
      logic full;
      logic limit;
      logic sweep_done;
      logic [1:0] rtype;
   } stat_type;
endpackage

/* design/chained_hash_map.sv */
`timescale 1ns / 1ps
// Key-value map with 256 buckets and 256 entries. After reset a clearing pass
// empties the bucket heads; no request is taken then. A request runs the
// 64-bit FNV-1a hash over its key bytes (one 16-bit partial product a cycle),
// reads the bucket head, then probes the chain entry by entry through the entry
// memories; one request at a time, and a new request beat is taken only once
// the previous response beat is gone.
module chained_hash_map
   import chm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic [63:0] req_key_bytes,
   input  logic [3:0]  req_key_len,
   input  logic [31:0] req_value_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_value_out,
   output logic [8:0]  rsp_entry_count
);
   cmd_type cmd;
   stat_type stat;
   logic [CntW-1:0] cnt;

   chm_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .stat, .cmd
   );

   chm_datapath u_dp (
      .clock, .reset, .cmd, .stat, .req_type, .req_key_bytes, .req_key_len,
      .req_value_in, .res_status(rsp_status), .res_value(rsp_value_out),
      .res_count(cnt)
   );

   assign rsp_entry_count = 9'(cnt);
endmodule

/* design/chm_datapath.sv */
`timescale 1ns / 1ps
module chm_datapath
   import chm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output stat_type    stat,
   input  logic [1:0]  req_type,
   input  logic [63:0] req_key_bytes,
   input  logic [3:0]  req_key_len,
   input  logic [31:0] req_value_in,
   output logic [1:0]  res_status,
   output logic [31:0] res_value,
   output logic [CntW-1:0] res_count
);
   // request registers
   logic [1:0]  type_ff;
   logic [63:0] key_ff;
   logic [3:0]  len_ff;
   logic [31:0] val_ff;
   // hash engine: byte index and 16-bit digit of the prime product
   logic [3:0]  byte_ff;
   logic [1:0]  dig_ff;
   logic [63:0] hash_ff, acc_ff, base_ff;
   // walk registers
   logic [LnkW-1:0] cur_ff, prev_ff, found_ff;
   logic [StepW-1:0] steps_ff;
   logic [CntW-1:0] count_ff;
   logic [BktW-1:0] sweep_ff;
   logic sweep_done_ff;
   logic [1:0]  st_ff;
   logic [31:0] vo_ff;

   // memories
   logic [LnkW-1:0] head_mem [NumBuckets];
   logic [63:0] key_mem [NumEntries];
   logic [3:0]  len_mem [NumEntries];
   logic [63:0] hash_mem [NumEntries];
   logic [31:0] val_mem [NumEntries];
   logic [LnkW-1:0] link_mem [NumEntries];
   logic [EntW-1:0] free_mem [NumEntries];
   logic [NumEntries-1:0] free_wr_ff; // free slot overwritten since reset

   logic [LnkW-1:0] head_rd_ff;
   logic [63:0] ekey_ff, ehash_ff;
   logic [3:0]  elen_ff;
   logic [31:0] evalue_ff;
   logic [LnkW-1:0] elink_ff;
   logic [EntW-1:0] free_rd_ff;

   logic [3:0]  len_sat;
   logic [63:0] mask;
   logic [BktW-1:0] bucket;
   logic [63:0] pp;
   logic [2:0]  nxt_byte;

   always_comb begin
      len_sat = (req_key_len > 4'(MaxKeyBytes)) ? 4'(MaxKeyBytes) : req_key_len;
      mask = '0;
      for (int i = 0; i < 8; i++) begin
         if (4'(i) < len_sat) mask[i*8 +: 8] = 8'hFF;
      end
      bucket = hash_ff[BktW-1:0];
      nxt_byte = byte_ff[2:0] + 3'd1;
      pp = 64'(base_ff[dig_ff*16 +: 16]) * FnvPrime;
   end

   // capture request and run the hash, one 16-bit digit per cycle
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         type_ff <= req_type;
         key_ff  <= req_key_bytes & mask;
         len_ff  <= len_sat;
         val_ff  <= req_value_in;
         byte_ff <= '0;
         dig_ff  <= '0;
         hash_ff <= FnvOffset;
         acc_ff  <= '0;
         base_ff <= FnvOffset ^ 64'(req_key_bytes[7:0]);
      end else if (cmd.hash_step && byte_ff < len_ff) begin
         if (dig_ff == 2'd3) begin
            hash_ff <= acc_ff + (pp << 48);
            base_ff <= (acc_ff + (pp << 48)) ^ 64'(key_ff[nxt_byte*8 +: 8]);
            acc_ff  <= '0;
            byte_ff <= byte_ff + 4'd1;
         end else begin
            acc_ff <= acc_ff + (pp << (dig_ff * 16));
         end
         dig_ff <= dig_ff + 2'd1;
      end
   end

   // bucket head memory and sweep
   always_ff @(posedge clock) begin
      if (cmd.clr_sweep) head_mem[sweep_ff] <= NilLink;
      else if (cmd.insert && prev_ff == NilLink) head_mem[bucket] <= LnkW'(free_rd_ff);
      else if (cmd.unlink && prev_ff == NilLink) head_mem[bucket] <= elink_ff;
      head_rd_ff <= head_mem[bucket];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
         sweep_done_ff <= 1'b0;
      end else if (cmd.clr_sweep) begin
         sweep_ff <= sweep_ff + 1'b1;
         if (sweep_ff == BktW'(NumBuckets - 1)) sweep_done_ff <= 1'b1;
      end
   end

   // entry memories
   always_ff @(posedge clock) begin
      if (cmd.insert) begin
         key_mem[free_rd_ff]  <= key_ff;
         len_mem[free_rd_ff]  <= len_ff;
         hash_mem[free_rd_ff] <= hash_ff;
         val_mem[free_rd_ff]  <= val_ff;
      end else if (cmd.wr_value) begin
         val_mem[found_ff[EntW-1:0]] <= val_ff;
      end
      ekey_ff   <= key_mem[cur_ff[EntW-1:0]];
      elen_ff   <= len_mem[cur_ff[EntW-1:0]];
      ehash_ff  <= hash_mem[cur_ff[EntW-1:0]];
      evalue_ff <= val_mem[cur_ff[EntW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.insert) link_mem[free_rd_ff] <= NilLink;
      else if (cmd.unlink && prev_ff != NilLink)
         link_mem[prev_ff[EntW-1:0]] <= elink_ff;
      if (cmd.insert && prev_ff != NilLink) link_mem[prev_ff[EntW-1:0]] <= LnkW'(free_rd_ff);
      elink_ff <= link_mem[cur_ff[EntW-1:0]];
   end

   // free stack: unwritten slot i reads as i
   always_ff @(posedge clock) begin
      if (cmd.unlink) free_mem[EntW'(count_ff - 1'b1)] <= found_ff[EntW-1:0];
      free_rd_ff <= free_wr_ff[EntW'(count_ff)] ? free_mem[EntW'(count_ff)]
                                               : EntW'(count_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) free_wr_ff <= '0;
      else if (cmd.unlink) free_wr_ff[EntW'(count_ff - 1'b1)] <= 1'b1;
   end

   // walk cursor, counters and result
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         if (cmd.insert) count_ff <= count_ff + 1'b1;
         else if (cmd.unlink && count_ff != '0) count_ff <= count_ff - 1'b1;
      end
      if (cmd.load) begin
         prev_ff <= NilLink;
         found_ff <= NilLink;
         steps_ff <= '0;
      end
      if (cmd.head_rd) cur_ff <= head_rd_ff;
      if (cmd.advance) begin
         prev_ff <= cur_ff;
         cur_ff <= elink_ff;
         steps_ff <= steps_ff + 1'b1;
      end
      if (cmd.found_set) found_ff <= cur_ff;
      if (cmd.finish) begin
         st_ff <= cmd.status;
         vo_ff <= (cmd.status == StOk && (type_ff == ReqGet || type_ff == ReqPop))
                  ? evalue_ff : 32'd0;
      end
   end

   assign stat.hash_done = (byte_ff >= len_ff);
   assign stat.at_nil = (cur_ff == NilLink);
   assign stat.match = (ehash_ff == hash_ff) && (elen_ff == len_ff) && (ekey_ff == key_ff);
   assign stat.is_found = (found_ff != NilLink);
   assign stat.full = (count_ff >= CntW'(NumEntries));
   assign stat.limit = (steps_ff >= StepW'(NumEntries));
   assign stat.sweep_done = sweep_done_ff;
   assign stat.rtype = type_ff;
   assign res_status = st_ff;
   assign res_value = vo_ff;
   assign res_count = count_ff;
endmodule

/* design/chm_ctrl.sv */
`timescale 1ns / 1ps
module chm_ctrl
   import chm_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   input  stat_type stat,
   output cmd_type  cmd
);
   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_HASH, S_HEAD, S_HEAD2, S_CHECK, S_READ, S_READ2,
      S_MATCH, S_ACT, S_FREE, S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd = '0;
      req_ready = 1'b0;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_sweep = !stat.sweep_done;
            if (stat.sweep_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            // accept when no result waits
            req_ready = !rsp_valid_ff;
            if (req_valid && !rsp_valid_ff) begin
               cmd.load = 1'b1;
               state_in = S_HASH;
            end
         end
         S_HASH: begin
            cmd.hash_step = 1'b1;
            if (stat.hash_done) state_in = S_HEAD;
         end
         S_HEAD: state_in = S_HEAD2;
         S_HEAD2: begin
            cmd.head_rd = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (stat.at_nil || stat.limit) state_in = S_ACT;
            else state_in = S_READ;
         end
         S_READ: state_in = S_READ2;
         S_READ2: state_in = S_MATCH;
         S_MATCH: begin
            if (stat.match) begin
               cmd.found_set = 1'b1;
               state_in = S_ACT;
            end else begin
               cmd.advance = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_ACT: begin
            state_in = S_DONE;
            if (stat.rtype == ReqSet) begin
               if (stat.is_found) begin
                  cmd.wr_value = 1'b1;
                  cmd.status = StOk;
               end else if (stat.full) begin
                  cmd.status = StFull;
               end else begin
                  cmd.insert = 1'b1;
                  cmd.status = StOk;
               end
            end else if (!stat.is_found) begin
               cmd.status = StMiss;
            end else begin
               cmd.status = StOk;
               if (stat.rtype != ReqGet) cmd.unlink = 1'b1;
            end
            cmd.finish = 1'b1;
         end
         S_DONE: begin
            rsp_valid_in = 1'b1;
            state_in = S_FREE;
         end
         S_FREE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
endmodule

/* design/chm_checker.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
module chm_checker
   import chm_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [31:0] rsp_value_out,
   input logic [8:0]  rsp_entry_count
);
   `ASSERT_IMPL(a_status_range, clock, reset, rsp_valid, rsp_status <= StFull)
   `ASSERT_IMPL(a_count_range, clock, reset, rsp_valid, rsp_entry_count <= 9'(NumEntries))
   `ASSERT_IMPL(a_miss_zero, clock, reset, rsp_valid && rsp_status == StMiss, rsp_value_out == 32'd0)
   `ASSERT_IMPL(a_one_at_time, clock, reset, rsp_valid, !req_ready)
endmodule

bind chained_hash_map chm_checker u_chk (.*);

/* tb/sv/tb_chained_hash_map.sv */
`timescale 1ns / 1ps
module tb_chained_hash_map;
   import chm_pkg::*;

   // map predictor and queue of expected responses
   class map_scoreboard;
      logic [LnkW-1:0] head_q[NumBuckets];
      logic [63:0] key_q[NumEntries];
      logic [3:0] len_q[NumEntries];
      logic [63:0] hash_q[NumEntries];
      logic [31:0] val_q[NumEntries];
      logic [LnkW-1:0] link_q[NumEntries];
      logic [EntW-1:0] free_q[NumEntries];
      int count;
      logic [1:0] exp_status[$];
      logic [31:0] exp_value[$];
      logic [8:0] exp_count[$];
      int errors;

      function new();
         for (int i = 0; i < NumBuckets; i++) head_q[i] = NilLink;
         for (int i = 0; i < NumEntries; i++) free_q[i] = EntW'(i);
         count = 0;
         errors = 0;
      endfunction

      // predict the response to one accepted request beat
      function void note_request(logic [1:0] rt, logic [63:0] kb, logic [3:0] kl,
                                 logic [31:0] vi);
         logic [3:0] len;
         logic [63:0] key, h;
         logic [BktW-1:0] bkt;
         int cur, prev, found, e;
         logic [1:0] st;
         logic [31:0] vo;
         len = (kl > MaxKeyBytes) ? 4'(MaxKeyBytes) : kl;
         key = (len >= 8) ? kb : (kb & ((64'd1 << (len * 8)) - 1));
         h = FnvOffset;
         for (int i = 0; i < len; i++) h = (h ^ ((key >> (i * 8)) & 64'hFF)) * FnvPrime;
         bkt = h[BktW-1:0];
         found = NumEntries;
         prev = NumEntries;
         cur = head_q[bkt];
         for (int s = 0; cur < NumEntries && s < NumEntries; s++) begin
            if (hash_q[cur] == h && len_q[cur] == len && key_q[cur] == key) begin
               found = cur;
               break;
            end
            prev = cur;
            cur = link_q[cur];
         end
         st = StOk;
         vo = '0;
         if (rt == ReqSet) begin
            if (found != NumEntries) val_q[found] = vi;
            else if (count >= NumEntries) st = StFull;
            else begin
               e = free_q[count];
               count++;
               key_q[e] = key;
               len_q[e] = len;
               hash_q[e] = h;
               val_q[e] = vi;
               link_q[e] = NilLink;
               if (prev == NumEntries) head_q[bkt] = LnkW'(e);
               else link_q[prev] = LnkW'(e);
            end
         end else if (found == NumEntries) begin
            st = StMiss;
         end else if (rt == ReqGet) begin
            vo = val_q[found];
         end else begin
            if (rt == ReqPop) vo = val_q[found];
            if (prev == NumEntries) head_q[bkt] = link_q[found];
            else link_q[prev] = link_q[found];
            if (count > 0) begin
               count--;
               free_q[count] = EntW'(found);
            end
         end
         exp_status.push_back(st);
         exp_value.push_back(vo);
         exp_count.push_back(9'(count));
      endfunction

      // compare one response beat with the oldest prediction
      function void check_response(logic [1:0] st, logic [31:0] vo, logic [8:0] cnt);
         logic [1:0] es;
         logic [31:0] ev;
         logic [8:0] ec;
         if (exp_status.size() == 0) begin
            $error("unexpected response beat");
            errors++;
            return;
         end
         es = exp_status.pop_front();
         ev = exp_value.pop_front();
         ec = exp_count.pop_front();
         if (st !== es) begin
            $error("status expected %0d actual %0d", es, st);
            errors++;
         end
         if (vo !== ev) begin
            $error("value_out expected %h actual %h", ev, vo);
            errors++;
         end
         if (cnt !== ec) begin
            $error("entry_count expected %0d actual %0d", ec, cnt);
            errors++;
         end
      endfunction

      function int pending();
         return exp_status.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_type = ReqGet;
   logic [63:0] req_key_bytes = '0;
   logic [3:0] req_key_len = '0;
   logic [31:0] req_value_in = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [1:0] rsp_status;
   logic [31:0] rsp_value_out;
   logic [8:0] rsp_entry_count;

   map_scoreboard sb = new();
   bit quiet = 1'b0;
   logic [63:0] pool_key[32];
   logic [3:0] pool_len[32];

   always #2 clock = ~clock;

   chained_hash_map u_dut (.*);

   // accept and check response beats
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response(rsp_status, rsp_value_out, rsp_entry_count);
   end

   // random stalls on the response side, in bursts
   initial begin
      int n;
      forever begin
         @(posedge clock);
         if (!quiet && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 11);
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   // drive one request beat and hold it until accepted; valid drops only on idling
   task automatic send_req(logic [1:0] rt, logic [63:0] kb, logic [3:0] kl,
                           logic [31:0] vi);
      int n;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         n = $urandom_range(1, 11);
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= rt;
      req_key_bytes <= kb;
      req_key_len <= kl;
      req_value_in <= vi;
      do @(posedge clock); while (!req_ready);
      sb.note_request(rt, kb, kl, vi);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // drop valid and hold off until every response has returned
   task automatic wait_drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   initial begin
      logic [1:0] rt;
      int p;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      // directed: empty key, extreme lengths, every request type, misses
      send_req(ReqGet, '1, 4'd0, '1);
      send_req(ReqSet, '1, 4'd0, 32'hFFFF_FFFF);
      send_req(ReqGet, '0, 4'd0, '0);
      send_req(ReqSet, '1, 4'd8, 32'h1234_5678);
      send_req(ReqGet, '1, 4'd15, '0);
      send_req(ReqSet, 64'h00FF_FFFF_FFFF_FFAB, 4'd1, 32'h0);
      send_req(ReqGet, 64'h0000_0000_0000_00AB, 4'd1, '1);
      send_req(ReqPop, 64'h1111_1111_1111_11AB, 4'd1, '0);
      send_req(ReqPop, 64'hAB, 4'd1, '0);
      send_req(ReqDel, '1, 4'd9, '0);
      send_req(ReqDel, '1, 4'd8, '0);
      send_req(ReqSet, '1, 4'd0, 32'h5A5A_A5A5);
      send_req(ReqPop, '0, 4'd0, '0);
      send_req(ReqDel, '0, 4'd3, '0);
      // fill the table past capacity, then update it and drain every entry
      for (int i = 0; i < 260; i++)
         send_req(ReqSet, 64'(i), (i % 2) ? 4'd2 : 4'd1, $urandom());
      send_req(ReqSet, 64'd5, 4'd1, 32'hCAFE_F00D);
      send_req(ReqSet, 64'hDEAD, 4'd4, '1);
      send_req(ReqGet, 64'd5, 4'd1, '0);
      for (int i = 0; i < 256; i++)
         send_req(($urandom_range(0, 1) != 0) ? ReqPop : ReqDel, 64'(i),
                  (i % 2) ? 4'd2 : 4'd1, '0);
      // hold off until every response has returned
      wait_drain();
      for (int i = 0; i < 32; i++) begin
         pool_key[i] = rand64();
         pool_len[i] = 4'($urandom_range(0, 15));
      end
      // random traffic mostly on a small key pool so entries hit and chain
      for (int i = 0; i < 1120; i++) begin
         if (i == 950) quiet = 1'b1;
         rt = 2'($urandom_range(0, 3));
         if ($urandom_range(0, 9) < 8) begin
            p = $urandom_range(0, 31);
            send_req(rt, pool_key[p] ^ (rand64() << (pool_len[p] * 8)), pool_len[p],
                     $urandom());
         end else begin
            send_req(rt, rand64(), 4'($urandom_range(0, 15)), $urandom());
         end
      end
      wait_drain();
      repeat (200) @(posedge clock);
      if (sb.errors == 0) $display("tb_chained_hash_map OK");
      else $display("tb_chained_hash_map NOT OK");
      $finish;
   end

   initial begin
      #40ms;
      $display("tb_chained_hash_map NOT OK");
      $finish;
   end
endmodule
